@@ rtl/core/ccs_pkg.sv @@
// Shared types, sizes and helpers for the contingency chi-square block.
// Used by contingency_chi_square and ccs_div; depends on nothing else.
`default_nettype none
package ccs_pkg;

	// Table geometry and arithmetic sizes.
	localparam int MAX_ALLELES = 64;
	localparam int MAX_STRATA  = 16;
	localparam int COUNT_BITS  = 16;
	localparam int FRAC_BITS   = 16;
	localparam int STAT_W      = 48;
	localparam int ROW_W       = $clog2(MAX_ALLELES);
	localparam int COL_W       = $clog2(MAX_STRATA);
	localparam int CELL_W      = ROW_W + COL_W;
	localparam int PROD_W      = 2 * COUNT_BITS;
	localparam int DEN_W       = 3 * COUNT_BITS;
	localparam int SQ_W        = 2 * PROD_W;
	localparam int NUM_W       = SQ_W + FRAC_BITS;
	localparam int ALLELE_CFG_W = 7;
	localparam int STRATA_CFG_W = 5;
	localparam int APB_DATA_W  = 32;
	localparam int APB_ADDR_W  = 3;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [STAT_W-1:0]     STAT_MAX  = {STAT_W{1'b1}};

	// Item kinds.
	localparam logic [1:0] KIND_OBSERVE   = 2'd0;
	localparam logic [1:0] KIND_CLOSE     = 2'd1;
	localparam logic [1:0] KIND_CLOSE_END = 2'd2;

	// Register indexes, taken from paddr[2].
	localparam logic REG_ALLELES = 1'b0;
	localparam logic REG_STRATA  = 1'b1;

	localparam logic [ALLELE_CFG_W-1:0] ALLELES_RESET = 7'd64;
	localparam logic [STRATA_CFG_W-1:0] STRATA_RESET  = 5'd16;

	typedef struct packed {
		logic [1:0]       kind;
		logic [ROW_W-1:0] allele;
		logic [COL_W-1:0] stratum;
		logic             missing;
	} obs_t;

	typedef struct packed {
		logic [STAT_W-1:0] locus_stat;
		logic [STAT_W-1:0] total_stat;
		logic              count_overflow;
		logic              sample_end;
	} res_t;

	// Saturating add of two statistics.
	function automatic logic [STAT_W-1:0] sat_add(input logic [STAT_W-1:0] a,
			input logic [STAT_W-1:0] b);
		logic [STAT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[STAT_W] ? STAT_MAX : s[STAT_W-1:0];
	endfunction

	// Saturating count increment.
	function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] v);
		return (v == COUNT_MAX) ? COUNT_MAX : v + 1'b1;
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/contingency_chi_square.sv @@
// Pearson chi-square over an allele-by-stratum count table, top level.
// Depends on ccs_pkg, ccs_ram and ccs_div.
//
// Observations are taken one per clock while the block is idle (not clearing
// or walking): the cell count and row total sit in RAMs and are updated
// read-modify-write, with forwarding for repeated cells. A close walks every
// cell of the table; each cell in use (nonzero row, column and sample totals,
// inside the configured rows and columns) also goes through the multiply
// steps and the one-bit-per-cycle divider. The walk also clears the table.
// After reset a clearing pass over all 1024 cells runs before the first
// observation is taken. Results are held in an output register, so
// observations keep flowing while a result waits.
`default_nettype none
module contingency_chi_square (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                obs_valid,
	output logic                                     obs_ready,
	input  wire ccs_pkg::obs_t                       obs,
	output logic                                     res_valid,
	input  wire logic                                res_ready,
	output ccs_pkg::res_t                            res,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [ccs_pkg::APB_ADDR_W-1:0]      paddr,
	input  wire logic [ccs_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [ccs_pkg::APB_DATA_W-1:0]           prdata,
	output logic                                     pready
);

	localparam int CB  = ccs_pkg::COUNT_BITS;
	localparam int RW  = ccs_pkg::ROW_W;
	localparam int CW  = ccs_pkg::COL_W;
	localparam int KW  = ccs_pkg::CELL_W;

	typedef enum logic [8:0] {
		ST_CLR    = 9'b000000001,
		ST_IDLE   = 9'b000000010,
		ST_RD     = 9'b000000100,
		ST_LD     = 9'b000001000,
		ST_MUL    = 9'b000010000,
		ST_SQ     = 9'b000100000,
		ST_DSTART = 9'b001000000,
		ST_DWAIT  = 9'b010000000,
		ST_EMIT   = 9'b100000000
	} state_t;

	state_t state_q;

	logic [ccs_pkg::ALLELE_CFG_W-1:0] alleles_q;
	logic [ccs_pkg::STRATA_CFG_W-1:0] strata_q;

	logic [KW-1:0]   k_q;
	logic [RW-1:0]   k_row;
	logic [CW-1:0]   k_col;

	logic            s1_valid_q;
	logic [RW-1:0]   s1_row_q;
	logic [CW-1:0]   s1_col_q;
	logic            fwd_vld_q;
	logic [KW-1:0]   fwd_addr_q;
	logic [CB-1:0]   fwd_cell_q, fwd_row_q;

	logic [CB-1:0]   col_tot_q [ccs_pkg::MAX_STRATA];
	logic [CB-1:0]   n_q;
	logic            ov_q;
	logic            end_q;
	logic [ccs_pkg::STAT_W-1:0] sum_q, total_q;

	logic [ccs_pkg::PROD_W-1:0] no_q, rc_q, nr_q, d_q;
	logic [CB-1:0]              c_q;
	logic [ccs_pkg::DEN_W-1:0]  den_q;
	logic [ccs_pkg::SQ_W-1:0]   sq_q;

	logic            res_valid_q;
	ccs_pkg::res_t   res_q;

	logic            tbl_we, all_we;
	logic [KW-1:0]   tbl_waddr, tbl_raddr;
	logic [RW-1:0]   all_waddr, all_raddr;
	logic [CB-1:0]   tbl_wdata, all_wdata, tbl_rd, all_rd;

	logic            obs_fire, obs_use, obs_close, cfg_write;
	logic [CB-1:0]   cell_cur, row_cur, col_cur;
	logic [CW-1:0]   col_idx;
	logic            cell_in_use;
	logic            walk_last;
	logic [ccs_pkg::STAT_W-1:0] total_nx;

	logic            div_start, div_busy, div_done;
	logic [ccs_pkg::STAT_W-1:0] div_quot;

	assign k_row     = k_q[KW-1:CW];
	assign k_col     = k_q[CW-1:0];
	assign walk_last = (k_q == {KW{1'b1}});

	// Input handshake and item decode.
	assign obs_ready = (state_q == ST_IDLE);
	assign obs_fire  = obs_valid && obs_ready;
	assign obs_close = (obs.kind == ccs_pkg::KIND_CLOSE) || (obs.kind == ccs_pkg::KIND_CLOSE_END);
	assign obs_use   = (obs.kind == ccs_pkg::KIND_OBSERVE) && !obs.missing &&
		(ccs_pkg::ALLELE_CFG_W'(obs.allele) < alleles_q) &&
		(ccs_pkg::STRATA_CFG_W'(obs.stratum) < strata_q);

	// Configuration port.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alleles_q <= ccs_pkg::ALLELES_RESET;
			strata_q  <= ccs_pkg::STRATA_RESET;
		end else if (cfg_write) begin
			unique case (paddr[2])
				ccs_pkg::REG_ALLELES: alleles_q <= pwdata[ccs_pkg::ALLELE_CFG_W-1:0];
				ccs_pkg::REG_STRATA:  strata_q  <= pwdata[ccs_pkg::STRATA_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			ccs_pkg::REG_ALLELES: prdata = ccs_pkg::APB_DATA_W'(alleles_q);
			ccs_pkg::REG_STRATA:  prdata = ccs_pkg::APB_DATA_W'(strata_q);
			default:              prdata = '0;
		endcase
	end

	// Current counts for the observation in its update stage (s1).
	assign col_idx = (state_q == ST_IDLE) ? s1_col_q : k_col;
	assign col_cur = col_tot_q[col_idx];

	always_comb begin
		cell_cur = (fwd_vld_q && fwd_addr_q == {s1_row_q, s1_col_q}) ? fwd_cell_q : tbl_rd;
		row_cur  = (fwd_vld_q && fwd_addr_q[KW-1:CW] == s1_row_q) ? fwd_row_q : all_rd;
	end

	// Memory port selection: clearing, walk, or observation update.
	always_comb begin
		tbl_raddr = (state_q == ST_IDLE) ? {obs.allele, obs.stratum} : k_q;
		all_raddr = (state_q == ST_IDLE) ? obs.allele : k_row;
		tbl_we    = 1'b0;
		tbl_waddr = k_q;
		tbl_wdata = '0;
		all_we    = 1'b0;
		all_waddr = k_row;
		all_wdata = '0;
		if (state_q == ST_CLR) begin
			tbl_we = 1'b1;
			all_we = 1'b1;
		end else if (state_q == ST_LD) begin
			tbl_we = 1'b1;
			all_we = (k_col == {CW{1'b1}});
		end else if (s1_valid_q) begin
			tbl_we    = 1'b1;
			tbl_waddr = {s1_row_q, s1_col_q};
			tbl_wdata = ccs_pkg::bump(cell_cur);
			all_we    = 1'b1;
			all_waddr = s1_row_q;
			all_wdata = ccs_pkg::bump(row_cur);
		end
	end

	ccs_ram #(.ADDR_W(KW), .DATA_W(CB)) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.raddr (tbl_raddr),
		.rdata (tbl_rd)
	);

	ccs_ram #(.ADDR_W(RW), .DATA_W(CB)) u_row_tot (
		.clk   (clk),
		.we    (all_we),
		.waddr (all_waddr),
		.wdata (all_wdata),
		.raddr (all_raddr),
		.rdata (all_rd)
	);

	// A cell contributes only with nonzero expected count inside the used area.
	assign cell_in_use = (ccs_pkg::ALLELE_CFG_W'(k_row) < alleles_q) &&
		(ccs_pkg::STRATA_CFG_W'(k_col) < strata_q) &&
		(all_rd != '0) && (col_cur != '0) && (n_q != '0);

	assign div_start = (state_q == ST_DSTART);
	assign total_nx  = ccs_pkg::sat_add(total_q, sum_q);

	ccs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ({sq_q, {ccs_pkg::FRAC_BITS{1'b0}}}),
		.den    (den_q),
		.busy   (div_busy),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			k_q         <= '0;
			s1_valid_q  <= 1'b0;
			fwd_vld_q   <= 1'b0;
			n_q         <= '0;
			ov_q        <= 1'b0;
			end_q       <= 1'b0;
			sum_q       <= '0;
			total_q     <= '0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < ccs_pkg::MAX_STRATA; i++) begin
				col_tot_q[i] <= '0;
			end
		end else begin
			s1_valid_q <= obs_fire && obs_use;
			fwd_vld_q  <= s1_valid_q;
			if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			// Update stage of an observation (s1_valid_q): update flop totals.
			if (s1_valid_q) begin
				col_tot_q[s1_col_q] <= ccs_pkg::bump(col_cur);
				n_q                 <= ccs_pkg::bump(n_q);
				if (cell_cur == ccs_pkg::COUNT_MAX || row_cur == ccs_pkg::COUNT_MAX ||
						col_cur == ccs_pkg::COUNT_MAX || n_q == ccs_pkg::COUNT_MAX) begin
					ov_q <= 1'b1;
				end
			end
			unique case (state_q)
				ST_CLR: begin
					k_q <= k_q + 1'b1;
					if (walk_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (obs_fire && obs_close) begin
						end_q   <= (obs.kind == ccs_pkg::KIND_CLOSE_END);
						sum_q   <= '0;
						k_q     <= '0;
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_LD;
				end
				ST_LD: begin
					if (cell_in_use) begin
						state_q <= ST_MUL;
					end else if (walk_last) begin
						state_q <= ST_EMIT;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= ST_RD;
					end
				end
				ST_MUL: begin
					state_q <= ST_SQ;
				end
				ST_SQ: begin
					state_q <= ST_DSTART;
				end
				ST_DSTART: begin
					state_q <= ST_DWAIT;
				end
				ST_DWAIT: begin
					if (div_done) begin
						sum_q <= ccs_pkg::sat_add(sum_q, div_quot);
						if (walk_last) begin
							state_q <= ST_EMIT;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= ST_RD;
						end
					end
				end
				ST_EMIT: begin
					if (!res_valid_q) begin
						res_valid_q <= 1'b1;
						total_q     <= end_q ? '0 : total_nx;
						n_q         <= '0;
						ov_q        <= 1'b0;
						for (int i = 0; i < ccs_pkg::MAX_STRATA; i++) begin
							col_tot_q[i] <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_CLR;
			endcase
		end
	end

	// Payload registers of the observation pipe, forwarding and arithmetic.
	always_ff @(posedge clk) begin
		s1_row_q   <= obs.allele;
		s1_col_q   <= obs.stratum;
		fwd_addr_q <= {s1_row_q, s1_col_q};
		fwd_cell_q <= ccs_pkg::bump(cell_cur);
		fwd_row_q  <= ccs_pkg::bump(row_cur);
		if (state_q == ST_LD) begin
			no_q <= ccs_pkg::PROD_W'(n_q) * ccs_pkg::PROD_W'(tbl_rd);
			rc_q <= ccs_pkg::PROD_W'(all_rd) * ccs_pkg::PROD_W'(col_cur);
			nr_q <= ccs_pkg::PROD_W'(n_q) * ccs_pkg::PROD_W'(all_rd);
			c_q  <= col_cur;
		end
		if (state_q == ST_MUL) begin
			d_q   <= (no_q >= rc_q) ? no_q - rc_q : rc_q - no_q;
			den_q <= ccs_pkg::DEN_W'(nr_q) * ccs_pkg::DEN_W'(c_q);
		end
		if (state_q == ST_SQ) begin
			sq_q <= ccs_pkg::SQ_W'(d_q) * ccs_pkg::SQ_W'(d_q);
		end
		if (state_q == ST_EMIT && !res_valid_q) begin
			res_q.locus_stat     <= sum_q;
			res_q.total_stat     <= total_nx;
			res_q.count_overflow <= ov_q;
			res_q.sample_end     <= end_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Checks on the sequencer.
	default clocking cb @(posedge clk); endclocking

	a_div_idle_start: assert property (disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	a_close_walk: assert property (disable iff (!arst_n)
		(obs_fire && obs_close) |=> (state_q == ST_RD && k_q == '0))
		else $error("close did not start the walk at the first cell");

	a_s1_follows_accept: assert property (disable iff (!arst_n)
		s1_valid_q |-> $past(obs_fire))
		else $error("count update without an accepted beat");

	a_emit_clears: assert property (disable iff (!arst_n)
		(state_q == ST_EMIT && !res_valid_q) |=> (res_valid_q && n_q == '0 && !ov_q))
		else $error("emit did not present a beat and clear the locus");

endmodule
`default_nettype wire

@@ rtl/core/ccs_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
`default_nettype none
module ccs_ram #(
	parameter int ADDR_W = 4,
	parameter int DATA_W = 16
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, old data on a same-edge write.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

@@ rtl/core/ccs_div.sv @@
// Restoring divider, one quotient bit per cycle, quotient saturated to STAT_W bits.
// Depends on ccs_pkg.
`default_nettype none
module ccs_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [ccs_pkg::NUM_W-1:0]  num,
	input  wire logic [ccs_pkg::DEN_W-1:0]  den,
	output logic                            busy,
	output logic                            done,
	output logic [ccs_pkg::STAT_W-1:0]      quot
);

	localparam int CNT_W = $clog2(ccs_pkg::NUM_W + 1);

	logic                        busy_q, done_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [ccs_pkg::NUM_W-1:0]   num_q;
	logic [ccs_pkg::DEN_W-1:0]   den_q, rem_q;
	logic [ccs_pkg::STAT_W-1:0]  q_q, quot_q;
	logic                        sat_q;

	logic [ccs_pkg::DEN_W:0]     rem_sh, rem_sub;
	logic                        ge;
	logic [ccs_pkg::STAT_W-1:0]  q_nx;
	logic                        sat_nx;

	// One restoring step.
	always_comb begin
		rem_sh  = {rem_q, num_q[ccs_pkg::NUM_W-1]};
		ge      = rem_sh >= {1'b0, den_q};
		rem_sub = rem_sh - {1'b0, den_q};
		q_nx    = {q_q[ccs_pkg::STAT_W-2:0], ge};
		sat_nx  = sat_q | q_q[ccs_pkg::STAT_W-1];
	end

	// Control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ccs_pkg::NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			q_q   <= '0;
			sat_q <= 1'b0;
		end else if (busy_q) begin
			num_q <= {num_q[ccs_pkg::NUM_W-2:0], 1'b0};
			rem_q <= ge ? rem_sub[ccs_pkg::DEN_W-1:0] : rem_sh[ccs_pkg::DEN_W-1:0];
			q_q   <= q_nx;
			sat_q <= sat_nx;
			if (cnt_q == CNT_W'(1)) begin
				quot_q <= sat_nx ? ccs_pkg::STAT_MAX : q_nx;
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = quot_q;

endmodule
`default_nettype wire
